FILE: hw/rtl/plane_normal_to_pose_unit_defines.svh
// assertion macros for the plane normal to pose unit
`ifndef PLANE_NORMAL_TO_POSE_UNIT_DEFINES_SVH
`define PLANE_NORMAL_TO_POSE_UNIT_DEFINES_SVH

// implication checked in the same cycle
`define PNP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define PNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pnp_pkg.sv
package pnp_pkg;

    localparam int unsigned FRAC       = 14;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = FRAC + 1;
    // stage 0 capture, 1 vectors, 2 squares, 3 sums, then root, setup, divide, format
    localparam int unsigned SQRT_FIRST = 4;
    localparam int unsigned DIV_SETUP  = SQRT_FIRST + SQRT_STEPS;
    localparam int unsigned DIV_FIRST  = DIV_SETUP + 1;
    localparam int unsigned FMT_STAGE  = DIV_FIRST + DIV_STEPS;
    localparam int unsigned NSTAGE     = FMT_STAGE + 1;
    localparam logic [14:0] THR_RESET  = 15'd16382;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        logic signed [23:0] d;
        logic               sel;
        logic [2:0][31:0]   xm;
        logic [2:0][31:0]   ym;
        logic [2:0]         xn;
        logic [2:0]         yn;
        logic [2:0][39:0]   p;
        logic [2:0][63:0]   xq;
        logic [2:0][63:0]   yq;
        logic [2:0][23:0]   sh;
        logic [63:0]        xrem;
        logic [63:0]        xres;
        logic [63:0]        yrem;
        logic [63:0]        yres;
        logic [2:0][47:0]   xd;
        logic [2:0][47:0]   yd;
        logic [47:0]        xden;
        logic [47:0]        yden;
        logic               xz;
        logic               yz;
        logic [2:0][14:0]   xqt;
        logic [2:0][14:0]   yqt;
        logic [2:0][15:0]   xr;
        logic [2:0][15:0]   yr;
    } t_item;

    // one step of the bitwise integer square root
    function automatic logic [127:0] f_sqrt_step(logic [63:0] rem, logic [63:0] res,
                                                 int unsigned j);
        logic [63:0] bit_v;
        logic [63:0] trial;
        bit_v = 64'd1 << (62 - 2 * j);
        trial = res + bit_v;
        if (rem >= trial) begin
            return {rem - trial, (res >> 1) + bit_v};
        end
        return {rem, res >> 1};
    endfunction

    function automatic logic [15:0] f_fmt(logic [14:0] q, logic neg, logic zero);
        if (zero) begin
            return 16'd0;
        end
        return neg ? -{1'b0, q} : {1'b0, q};
    endfunction

    function automatic t_item f_step(t_item s, int unsigned k);
        t_item              o;
        logic signed [31:0] ab, ac, bc, aa, bb, cc;
        logic signed [33:0] xv [3];
        logic signed [16:0] yv [3];
        logic signed [39:0] pv;
        logic [40:0]        m;
        logic [26:0]        rq;
        logic [127:0]       sq;
        logic [47:0]        dsh;
        int unsigned        bi;
        o = s;
        if (k == 1) begin
            ab = s.a * s.b;
            ac = s.a * s.c;
            bc = s.b * s.c;
            aa = s.a * s.a;
            bb = s.b * s.b;
            cc = s.c * s.c;
            if (s.sel) begin
                yv[0] = -17'(s.c);
                yv[1] = 17'sd0;
                yv[2] = 17'(s.a);
                xv[0] = -34'(ab);
                xv[1] = 34'(aa) + 34'(cc);
                xv[2] = -34'(bc);
            end else begin
                yv[0] = 17'sd0;
                yv[1] = 17'(s.c);
                yv[2] = -17'(s.b);
                xv[0] = 34'(bb) + 34'(cc);
                xv[1] = -34'(ab);
                xv[2] = -34'(ac);
            end
            for (int i = 0; i < 3; i++) begin
                o.xn[i] = xv[i][33];
                o.xm[i] = xv[i][33] ? 32'(-xv[i]) : 32'(xv[i]);
                o.yn[i] = yv[i][16];
                o.ym[i] = yv[i][16] ? 32'(-yv[i]) : 32'(yv[i]);
            end
            pv = s.a * s.d;
            o.p[0] = pv;
            pv = s.b * s.d;
            o.p[1] = pv;
            pv = s.c * s.d;
            o.p[2] = pv;
        end else if (k == 2) begin
            for (int i = 0; i < 3; i++) begin
                o.xq[i] = {32'd0, s.xm[i]} * {32'd0, s.xm[i]};
                o.yq[i] = {32'd0, s.ym[i]} * {32'd0, s.ym[i]};
            end
        end else if (k == 3) begin
            o.xrem = s.xq[0] + s.xq[1] + s.xq[2];
            o.yrem = s.yq[0] + s.yq[1] + s.yq[2];
            o.xres = 64'd0;
            o.yres = 64'd0;
            for (int i = 0; i < 3; i++) begin
                pv = $signed(s.p[i]);
                m  = pv[39] ? 41'(-{pv[39], pv}) : {1'b0, pv};
                rq = 27'((m + (41'd1 << (FRAC - 1))) >> FRAC);
                if (pv > 40'sd0) begin
                    o.sh[i] = (rq > 27'd8388608) ? 24'h800000 : 24'(-rq);
                end else begin
                    o.sh[i] = (rq > 27'd8388607) ? 24'h7FFFFF : rq[23:0];
                end
            end
        end else if (k >= SQRT_FIRST && k < DIV_SETUP) begin
            sq     = f_sqrt_step(s.xrem, s.xres, k - SQRT_FIRST);
            o.xrem = sq[127:64];
            o.xres = sq[63:0];
            sq     = f_sqrt_step(s.yrem, s.yres, k - SQRT_FIRST);
            o.yrem = sq[127:64];
            o.yres = sq[63:0];
        end else if (k == DIV_SETUP) begin
            o.xz   = (s.xres[31:0] == 32'd0);
            o.yz   = (s.yres[31:0] == 32'd0);
            o.xden = {15'd0, s.xres[31:0], 1'b0};
            o.yden = {15'd0, s.yres[31:0], 1'b0};
            for (int i = 0; i < 3; i++) begin
                o.xd[i]  = ({16'd0, s.xm[i]} << (FRAC + 1)) + {16'd0, s.xres[31:0]};
                o.yd[i]  = ({16'd0, s.ym[i]} << (FRAC + 1)) + {16'd0, s.yres[31:0]};
                o.xqt[i] = 15'd0;
                o.yqt[i] = 15'd0;
            end
        end else if (k >= DIV_FIRST && k < FMT_STAGE) begin
            // quotient never exceeds 2^FRAC since each component is at most the norm
            bi = DIV_STEPS - 1 - (k - DIV_FIRST);
            for (int i = 0; i < 3; i++) begin
                dsh = s.xden << bi;
                if (s.xd[i] >= dsh) begin
                    o.xd[i]      = s.xd[i] - dsh;
                    o.xqt[i][bi] = 1'b1;
                end
                dsh = s.yden << bi;
                if (s.yd[i] >= dsh) begin
                    o.yd[i]      = s.yd[i] - dsh;
                    o.yqt[i][bi] = 1'b1;
                end
            end
        end else if (k == FMT_STAGE) begin
            for (int i = 0; i < 3; i++) begin
                o.xr[i] = f_fmt(s.xqt[i], s.xn[i], s.xz);
                o.yr[i] = f_fmt(s.yqt[i], s.yn[i], s.yz);
            end
        end
        return o;
    endfunction

endpackage

FILE: hw/rtl/plane_normal_to_pose_unit.sv
// pipeline: input is registered into stage 0 and passes through every stage register up to the format stage
// throughput: one word per cycle unless stalled; every square root and divide step has a stage of its own
// stall: the whole pipeline holds while the last stage waits for i_ready
// reset: synchronous active low, clears all valid bits and loads threshold 16382
module plane_normal_to_pose_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [23:0] i_plane_offset,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_rot_xx,
    output logic signed [15:0] o_rot_xy,
    output logic signed [15:0] o_rot_xz,
    output logic signed [15:0] o_rot_yx,
    output logic signed [15:0] o_rot_yy,
    output logic signed [15:0] o_rot_yz,
    output logic signed [15:0] o_rot_zx,
    output logic signed [15:0] o_rot_zy,
    output logic signed [15:0] o_rot_zz,
    output logic signed [23:0] o_shift_x,
    output logic signed [23:0] o_shift_y,
    output logic signed [23:0] o_shift_z
);

    localparam int unsigned N = pnp_pkg::NSTAGE;

    logic [14:0]           r_thr;
    pnp_pkg::t_item        r_pipe [N];
    pnp_pkg::t_item        n_pipe [N];
    logic [N-1:0]          r_vld;
    logic                  adv;
    logic [15:0]           a_mag;

    assign adv     = i_ready || !r_vld[N-1];
    assign o_ready = adv;
    assign a_mag   = i_normal_x[15] ? 16'(-i_normal_x) : i_normal_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= pnp_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    always_comb begin
        n_pipe[0]     = r_pipe[0];
        n_pipe[0].a   = i_normal_x;
        n_pipe[0].b   = i_normal_y;
        n_pipe[0].c   = i_normal_z;
        n_pipe[0].d   = i_plane_offset;
        n_pipe[0].sel = ({1'b0, a_mag} > {2'b0, r_thr});
    end

    for (genvar g = 1; g < N; g++) begin : g_stage
        assign n_pipe[g] = pnp_pkg::f_step(r_pipe[g-1], g);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < N; s++) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    assign o_valid   = r_vld[N-1];
    assign o_rot_xx  = r_pipe[N-1].xr[0];
    assign o_rot_yx  = r_pipe[N-1].xr[1];
    assign o_rot_zx  = r_pipe[N-1].xr[2];
    assign o_rot_xy  = r_pipe[N-1].yr[0];
    assign o_rot_yy  = r_pipe[N-1].yr[1];
    assign o_rot_zy  = r_pipe[N-1].yr[2];
    assign o_rot_xz  = r_pipe[N-1].a;
    assign o_rot_yz  = r_pipe[N-1].b;
    assign o_rot_zz  = r_pipe[N-1].c;
    assign o_shift_x = r_pipe[N-1].sh[0];
    assign o_shift_y = r_pipe[N-1].sh[1];
    assign o_shift_z = r_pipe[N-1].sh[2];

endmodule

FILE: hw/rtl/pnp_checker.sv
`include "plane_normal_to_pose_unit_defines.svh"

module pnp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_rot_xy,
    input logic signed [15:0] o_rot_yx,
    input logic signed [15:0] o_rot_xz
);

    `PNP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_rot_xz), "stalled output word changed")
    `PNP_ASSERT_NOW(a_ready_rule, i_clk, i_rst_n, 1'b1, o_ready == (i_ready || !o_valid), "input ready does not follow output side")
    `PNP_ASSERT_NOW(a_unit_range, i_clk, i_rst_n, o_valid, o_rot_xy >= -16'sd16384 && o_rot_xy <= 16'sd16384 && o_rot_yx >= -16'sd16384 && o_rot_yx <= 16'sd16384, "unit axis component out of range")

endmodule

bind plane_normal_to_pose_unit pnp_checker u_pnp_checker (.*);
